@@ rtl/sbh_pkg.sv @@
// sbh_pkg: shared types, constants and state encodings for the sonar ball-height pid block
// no dependencies; used by every file under rtl
package sbh_pkg;

  // field widths
  localparam int ADC_W    = 16;
  localparam int ECHO_W   = 16;
  localparam int GAIN_W   = 24;
  localparam int IVL_W    = 10;
  localparam int TARGET_W = 7;
  localparam int DIST_W   = 17;
  localparam int ERR_W    = 18;
  localparam int INTEG_W  = 48;
  localparam int CFG_IDX_W = 2;

  // parameter defaults
  localparam int PWM_BITS_DEF    = 10;
  localparam int ECHO_MAX_US_DEF = 18500;
  localparam int QUEUE_DEPTH_DEF = 2;

  // target scaling
  localparam int ADC_LIMIT   = 2048;
  localparam int ADC_FULL    = 2047;
  localparam int TARGET_SPAN = 80;
  localparam int TARGET_BASE = 10;

  // distance scaling: echo * 256 / 58 == (echo << 7) / 29
  localparam int CM_DIVISOR   = 58;
  localparam int DIST_DIV     = CM_DIVISOR / 2;
  localparam int RECIP_SHIFT  = 28;
  localparam int RECIP_W      = 24;
  localparam logic [RECIP_W-1:0] DIST_RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DIST_DIV) - 64'd1) / 64'(DIST_DIV));
  localparam int DIST_MAX     = 131071;

  // derivative divider
  localparam int DIV_BITS  = 42;
  localparam int DIV_CNT_W = 6;

  // register reset values
  localparam logic [GAIN_W-1:0] GAIN_P_RST   = 24'd6400;
  localparam logic [GAIN_W-1:0] GAIN_I_RST   = 24'd1280;
  localparam logic [GAIN_W-1:0] GAIN_D_RST   = 24'd2048000;
  localparam logic [IVL_W-1:0]  INTERVAL_RST = 10'd23;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P,
    CFG_GAIN_I,
    CFG_GAIN_D,
    CFG_INTERVAL
  } sbh_cfg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [IVL_W-1:0]  interval_ms;
  } sbh_cfg_t;

  typedef struct packed {
    logic [TARGET_W-1:0] target_cm;
    logic [DIST_W-1:0]   distance_q8;
  } sbh_job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_FIX
  } sbh_front_state_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_ERR,
    B_MUL,
    B_INT,
    B_IMUL,
    B_IADD,
    B_DIV,
    B_SUM1,
    B_SUM2,
    B_OUT
  } sbh_back_state_t;

endpackage

@@ rtl/sbh_front.sv @@
// sbh_front: takes a request, decodes target and distance, pushes a job to the queue
// depends on sbh_pkg
module sbh_front #(
  parameter int ECHO_MAX_US = sbh_pkg::ECHO_MAX_US_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [sbh_pkg::ADC_W-1:0]       in_adc_word,
  input  logic [sbh_pkg::ECHO_W-1:0]      in_echo_width_us,
  input  logic                            q_full,
  output logic                            q_push,
  output sbh_pkg::sbh_job_t               q_job
);

  localparam logic [sbh_pkg::ECHO_W-1:0] ECHO_CAP = sbh_pkg::ECHO_W'(ECHO_MAX_US);
  localparam int Y_W  = sbh_pkg::ECHO_W + 7;
  localparam int X_W  = 18;
  localparam int RP_W = Y_W + sbh_pkg::RECIP_W;
  localparam int QD_W = RP_W - sbh_pkg::RECIP_SHIFT;

  sbh_pkg::sbh_front_state_t state_r, state_nxt;

  logic [X_W-1:0]  x_r;
  logic [Y_W-1:0]  y_r;
  logic [RP_W-1:0] rprod_r;
  logic [sbh_pkg::TARGET_W-1:0] tq0_r;

  logic [15:0] swapped;
  logic [11:0] v_raw, v_clip;
  logic [X_W-1:0] x_c;
  logic [sbh_pkg::ECHO_W-1:0] echo_cap_c;
  logic accept;

  logic [QD_W-1:0] qd_c, dq_c;
  logic [23:0]     qd29_c;
  logic [X_W-1:0]  tr_c;
  logic [sbh_pkg::TARGET_W-1:0] tq_c;

  assign accept = in_valid && !in_stall;

  // byte swap, drop the four low bits, out-of-range reads as zero
  assign swapped    = {in_adc_word[7:0], in_adc_word[15:8]};
  assign v_raw      = swapped[15:4];
  assign v_clip     = (v_raw > 12'(sbh_pkg::ADC_LIMIT)) ? 12'd0 : v_raw;
  // v * 80 as two shifts
  assign x_c        = {v_clip, 6'b0} + {2'b0, v_clip, 4'b0};
  assign echo_cap_c = (in_echo_width_us > ECHO_CAP) ? ECHO_CAP : in_echo_width_us;

  // reciprocal estimate is q or q+1
  assign qd_c   = rprod_r[RP_W-1:sbh_pkg::RECIP_SHIFT];
  assign qd29_c = 24'(qd_c) * 24'(sbh_pkg::DIST_DIV);
  assign dq_c   = ({1'b0, y_r} < qd29_c) ? (qd_c - QD_W'(1)) : qd_c;

  // x / 2047 is x >> 11 or one more
  assign tr_c = x_r - ({tq0_r, 11'b0} - X_W'(tq0_r));
  assign tq_c = (tr_c >= X_W'(sbh_pkg::ADC_FULL)) ? (tq0_r + 7'd1) : tq0_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sbh_pkg::F_IDLE: if (in_valid) state_nxt = sbh_pkg::F_MUL;
      sbh_pkg::F_MUL:  state_nxt = sbh_pkg::F_FIX;
      sbh_pkg::F_FIX:  if (!q_full) state_nxt = sbh_pkg::F_IDLE;
      default:         state_nxt = sbh_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    q_push   = 1'b0;
    case (state_r)
      sbh_pkg::F_IDLE: in_stall = 1'b0;
      sbh_pkg::F_FIX:  q_push = !q_full;
      default: begin
        in_stall = 1'b1;
        q_push   = 1'b0;
      end
    endcase
  end

  always_comb begin
    q_job.target_cm   = tq_c + 7'(sbh_pkg::TARGET_BASE);
    q_job.distance_q8 = (dq_c > QD_W'(sbh_pkg::DIST_MAX)) ?
                        sbh_pkg::DIST_W'(sbh_pkg::DIST_MAX) : dq_c[sbh_pkg::DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sbh_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r <= x_c;
      y_r <= {echo_cap_c, 7'b0};
    end
    if (state_r == sbh_pkg::F_MUL) begin
      rprod_r <= RP_W'(y_r) * RP_W'(sbh_pkg::DIST_RECIP);
      tq0_r   <= x_r[X_W-1:11];
    end
  end

`ifndef SYNTHESIS
  // one request at a time: front goes busy right after taking one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("front took a request without going busy");
`endif

endmodule

@@ rtl/sbh_queue.sv @@
// sbh_queue: small register fifo of decoded jobs between front and back
// depends on sbh_pkg
module sbh_queue #(
  parameter int DEPTH = sbh_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sbh_pkg::sbh_job_t push_job,
  input  logic              pop,
  output sbh_pkg::sbh_job_t pop_job,
  output logic              full,
  output logic              empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = PTR_W + 1;

  sbh_pkg::sbh_job_t entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign pop_job = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count past depth");
`endif

endmodule

@@ rtl/sbh_back.sv @@
// sbh_back: pid sequencer; error, saturating integral, serial derivative divide, output clamp
// depends on sbh_pkg
module sbh_back #(
  parameter int PWM_BITS = sbh_pkg::PWM_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  sbh_pkg::sbh_cfg_t                  cfg,
  input  logic                               q_empty,
  input  sbh_pkg::sbh_job_t                  q_job,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [PWM_BITS-1:0]                out_pwm_duty,
  output logic [sbh_pkg::TARGET_W-1:0]       out_target_cm,
  output logic [sbh_pkg::DIST_W-1:0]         out_distance_q8,
  output logic signed [sbh_pkg::ERR_W-1:0]   out_error_q8,
  output logic                               out_output_clipped
);

  localparam int EW  = sbh_pkg::ERR_W;
  localparam int IW  = sbh_pkg::INTEG_W;
  localparam int GW  = sbh_pkg::GAIN_W;
  localparam int VW  = sbh_pkg::IVL_W;
  localparam int DB  = sbh_pkg::DIV_BITS;
  localparam int IPW = EW + VW + 1;        // err * interval
  localparam int PTW = EW + GW + 1;        // p term
  localparam int DPW = EW + 1 + GW + 1;    // gain_d * delta
  localparam int PPW = 2 * GW;             // partial products of the i term
  localparam int SW  = 64;

  sbh_pkg::sbh_back_state_t state_r, state_nxt;

  logic [sbh_pkg::TARGET_W-1:0] target_r;
  logic [sbh_pkg::DIST_W-1:0]   dist_r;
  logic signed [EW-1:0]   err_r, prev_r;
  logic signed [EW:0]     delta_r;
  logic [VW-1:0]          iv_r;
  logic signed [IW-1:0]   integ_r;
  logic signed [IPW-1:0]  iprod_r;
  logic signed [PTW-1:0]  pterm_r;
  logic signed [DPW-1:0]  dprod_r;
  logic                   dneg_r, ineg_r, huge_r;
  logic [PPW-1:0]         pp_lo_r, pp_hi_r;
  logic signed [SW-1:0]   iterm_r;
  logic [DB-1:0]          div_num_r;
  logic [VW-1:0]          div_rem_r;
  logic [sbh_pkg::DIV_CNT_W-1:0] cnt_r;
  logic signed [PTW+1:0]  pd_r;
  logic signed [SW-1:0]   sum_r;

  logic                   out_valid_r;
  logic [PWM_BITS-1:0]    duty_r;
  logic                   clipped_r;
  logic [sbh_pkg::TARGET_W-1:0] out_target_r;
  logic [sbh_pkg::DIST_W-1:0]   out_dist_r;
  logic signed [EW-1:0]   out_err_r;

  logic signed [EW-1:0]   err_c;
  logic signed [IW:0]     isum_c;
  logic signed [IW-1:0]   integ_c;
  logic [IW-1:0]          imag_c;
  logic [DPW-1:0]         dmag_c;
  logic [PPW+GW-1:0]      iprod72_c;
  logic                   huge_c;
  logic [VW:0]            rem_sh_c;
  logic                   ge_c;
  logic signed [DPW-1:0]  dterm_c;
  logic [PWM_BITS-1:0]    duty_c;
  logic                   clipped_c;
  logic                   slot_free, out_load, div_last;

  assign slot_free = !out_valid_r || !out_stall;
  assign div_last  = (cnt_r == sbh_pkg::DIV_CNT_W'(DB - 1));

  // error
  assign err_c   = $signed({1'b0, dist_r}) - $signed({3'b0, target_r, 8'b0});

  // integral with saturation to 48 bits
  assign isum_c  = {integ_r[IW-1], integ_r} + {{(IW + 1 - IPW){iprod_r[IPW-1]}}, iprod_r};
  always_comb begin
    if (isum_c[IW] != isum_c[IW-1]) begin
      integ_c = isum_c[IW] ? {1'b1, {(IW - 1){1'b0}}} : {1'b0, {(IW - 1){1'b1}}};
    end else begin
      integ_c = isum_c[IW-1:0];
    end
  end

  assign imag_c = integ_r[IW-1] ? (IW'(0) - integ_r) : integ_r;
  assign dmag_c = dprod_r[DPW-1] ? (DPW'(0) - dprod_r) : dprod_r;

  // |integral| * gain_i from two 24x24 partial products
  assign iprod72_c = {pp_hi_r, {GW{1'b0}}} + {{GW{1'b0}}, pp_lo_r};
  assign huge_c    = (iprod72_c[PPW+GW-1:63] != '0) ||
                     (iprod72_c[62] && (iprod72_c[61:0] != '0));

  // restoring divide, one quotient bit a cycle
  assign rem_sh_c = {div_rem_r, div_num_r[DB-1]};
  assign ge_c     = (rem_sh_c >= {1'b0, iv_r});

  assign dterm_c = dneg_r ? (DPW'(0) - {{(DPW - DB){1'b0}}, div_num_r})
                          : {{(DPW - DB){1'b0}}, div_num_r};

  // clamp of the truncated sum
  always_comb begin
    duty_c    = sum_r[16 +: PWM_BITS];
    clipped_c = 1'b0;
    if (huge_r) begin
      clipped_c = 1'b1;
      duty_c    = (integ_r > 0) ? {PWM_BITS{1'b1}} : '0;
    end else if (sum_r[SW-1]) begin
      duty_c    = '0;
      clipped_c = (sum_r <= -SW'(65536));
    end else if (sum_r[SW-2:16+PWM_BITS] != '0) begin
      duty_c    = {PWM_BITS{1'b1}};
      clipped_c = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sbh_pkg::B_IDLE: if (!q_empty) state_nxt = sbh_pkg::B_ERR;
      sbh_pkg::B_ERR:  state_nxt = sbh_pkg::B_MUL;
      sbh_pkg::B_MUL:  state_nxt = sbh_pkg::B_INT;
      sbh_pkg::B_INT:  state_nxt = sbh_pkg::B_IMUL;
      sbh_pkg::B_IMUL: state_nxt = sbh_pkg::B_IADD;
      sbh_pkg::B_IADD: state_nxt = sbh_pkg::B_DIV;
      sbh_pkg::B_DIV:  if (div_last) state_nxt = sbh_pkg::B_SUM1;
      sbh_pkg::B_SUM1: state_nxt = sbh_pkg::B_SUM2;
      sbh_pkg::B_SUM2: state_nxt = sbh_pkg::B_OUT;
      sbh_pkg::B_OUT:  if (slot_free) state_nxt = sbh_pkg::B_IDLE;
      default:         state_nxt = sbh_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    out_load = 1'b0;
    case (state_r)
      sbh_pkg::B_IDLE: q_pop = !q_empty;
      sbh_pkg::B_OUT:  out_load = slot_free;
      default: begin
        q_pop    = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  // control state and pid state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sbh_pkg::B_IDLE;
      integ_r     <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_load || (out_valid_r && out_stall);
      if (state_r == sbh_pkg::B_ERR) begin
        prev_r <= err_c;
      end
      if (state_r == sbh_pkg::B_INT) begin
        integ_r <= integ_c;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      sbh_pkg::B_IDLE: begin
        target_r <= q_job.target_cm;
        dist_r   <= q_job.distance_q8;
      end
      sbh_pkg::B_ERR: begin
        err_r   <= err_c;
        delta_r <= {err_c[EW-1], err_c} - {prev_r[EW-1], prev_r};
        iv_r    <= (cfg.interval_ms == '0) ? VW'(1) : cfg.interval_ms;
      end
      sbh_pkg::B_MUL: begin
        iprod_r <= IPW'($signed(err_r) * $signed({1'b0, iv_r}));
        pterm_r <= PTW'($signed(err_r) * $signed({1'b0, cfg.gain_p}));
        dprod_r <= DPW'($signed(delta_r) * $signed({1'b0, cfg.gain_d}));
      end
      sbh_pkg::B_INT: begin
        dneg_r    <= dprod_r[DPW-1];
        div_num_r <= dmag_c[DB-1:0];
      end
      sbh_pkg::B_IMUL: begin
        ineg_r  <= integ_r[IW-1];
        pp_lo_r <= PPW'(imag_c[GW-1:0]) * PPW'(cfg.gain_i);
        pp_hi_r <= PPW'(imag_c[IW-1:GW]) * PPW'(cfg.gain_i);
      end
      sbh_pkg::B_IADD: begin
        huge_r    <= huge_c;
        iterm_r   <= ineg_r ? (SW'(0) - iprod72_c[SW-1:0]) : iprod72_c[SW-1:0];
        cnt_r     <= '0;
        div_rem_r <= '0;
      end
      sbh_pkg::B_DIV: begin
        div_rem_r <= ge_c ? VW'(rem_sh_c - {1'b0, iv_r}) : rem_sh_c[VW-1:0];
        div_num_r <= {div_num_r[DB-2:0], ge_c};
        cnt_r     <= cnt_r + sbh_pkg::DIV_CNT_W'(1);
      end
      sbh_pkg::B_SUM1: begin
        pd_r <= {pterm_r[PTW-1], pterm_r[PTW-1], pterm_r} + {dterm_c[DPW-1], dterm_c};
      end
      sbh_pkg::B_SUM2: begin
        sum_r <= {{(SW - PTW - 2){pd_r[PTW+1]}}, pd_r} + iterm_r;
      end
      sbh_pkg::B_OUT: begin
        if (out_load) begin
          duty_r       <= duty_c;
          clipped_r    <= clipped_c;
          out_target_r <= target_r;
          out_dist_r   <= dist_r;
          out_err_r    <= err_r;
        end
      end
      default: begin
      end
    endcase
  end

  // result fields come only from the result register, so they hold while stalled
  assign out_valid          = out_valid_r;
  assign out_pwm_duty       = duty_r;
  assign out_target_cm      = out_target_r;
  assign out_distance_q8    = out_dist_r;
  assign out_error_q8       = out_err_r;
  assign out_output_clipped = clipped_r;

`ifndef SYNTHESIS
  a_pop_starts_job: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == sbh_pkg::B_ERR))
    else $error("job popped but sequencer did not start");
  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || !out_stall))
    else $error("result overwrote a waiting result");
  a_unclipped_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && !clipped_c) |-> !huge_r)
    else $error("saturated i term reported as unclipped");
`endif

endmodule

@@ rtl/sonar_ball_height_pid.sv @@
// sonar_ball_height_pid: top level; config registers, front decode, job queue, pid back end
// depends on sbh_pkg, sbh_front, sbh_queue, sbh_back
//
// Ball-height fan controller. Each request carries a byte-swapped ADC word (setpoint pot)
// and a sonar echo width in us; each request gives exactly one result with the fan duty,
// the target in whole cm, the measured distance (Q9.8 cm), the error (distance minus
// target, Q.8) and a flag that the duty was clamped. The front end takes one request
// at a time (in_stall is high while it decodes or waits for queue room), turns the
// pot word into a 10..90 cm target and the echo into distance with a reciprocal
// multiply, and drops the job into a small fifo. The back end runs the pid: saturating
// 48-bit integral of error*interval, p term from one multiply, i term from 24x24
// partial products, and a derivative divided by interval_ms in a 42-step restoring
// divider. It works one job at a time; its result register holds a finished result
// while the next job already runs. Gains are unsigned Q16.8; an interval of 0 acts
// as 1. Write config only while the block is idle. cfg_ready is always high.
module sonar_ball_height_pid #(
  parameter int PWM_BITS    = sbh_pkg::PWM_BITS_DEF,
  parameter int ECHO_MAX_US = sbh_pkg::ECHO_MAX_US_DEF,
  parameter int QUEUE_DEPTH = sbh_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [sbh_pkg::ADC_W-1:0]           in_adc_word,
  input  logic [sbh_pkg::ECHO_W-1:0]          in_echo_width_us,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [PWM_BITS-1:0]                 out_pwm_duty,
  output logic [sbh_pkg::TARGET_W-1:0]        out_target_cm,
  output logic [sbh_pkg::DIST_W-1:0]          out_distance_q8,
  output logic signed [sbh_pkg::ERR_W-1:0]    out_error_q8,
  output logic                                out_output_clipped,
  // config write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sbh_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sbh_pkg::GAIN_W-1:0]          cfg_wdata
);

  sbh_pkg::sbh_cfg_t cfg_r, cfg_nxt;
  sbh_pkg::sbh_job_t push_job, pop_job;
  logic q_push, q_pop, q_full, q_empty;

  // config writes always taken
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (sbh_pkg::sbh_cfg_idx_t'(cfg_index))
        sbh_pkg::CFG_GAIN_P:   cfg_nxt.gain_p      = cfg_wdata;
        sbh_pkg::CFG_GAIN_I:   cfg_nxt.gain_i      = cfg_wdata;
        sbh_pkg::CFG_GAIN_D:   cfg_nxt.gain_d      = cfg_wdata;
        sbh_pkg::CFG_INTERVAL: cfg_nxt.interval_ms = cfg_wdata[sbh_pkg::IVL_W-1:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p      <= sbh_pkg::GAIN_P_RST;
      cfg_r.gain_i      <= sbh_pkg::GAIN_I_RST;
      cfg_r.gain_d      <= sbh_pkg::GAIN_D_RST;
      cfg_r.interval_ms <= sbh_pkg::INTERVAL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // request decode
  sbh_front #(
    .ECHO_MAX_US (ECHO_MAX_US)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_adc_word      (in_adc_word),
    .in_echo_width_us (in_echo_width_us),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_job            (push_job)
  );

  // decoded jobs waiting for the pid
  sbh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  // pid sequencer and result register
  sbh_back #(
    .PWM_BITS (PWM_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .q_empty            (q_empty),
    .q_job              (pop_job),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pwm_duty       (out_pwm_duty),
    .out_target_cm      (out_target_cm),
    .out_distance_q8    (out_distance_q8),
    .out_error_q8       (out_error_q8),
    .out_output_clipped (out_output_clipped)
  );

endmodule

@@ verif/sbh_pid_checker.sv @@
`timescale 1ns / 1ps
// sbh_pid_checker: follows the config, request and result channels of the pid block, keeps
// its own controller state, predicts each result and compares it field by field
// depends on sbh_pkg
module sbh_pid_checker #(
  parameter int PWM_BITS    = sbh_pkg::PWM_BITS_DEF,
  parameter int ECHO_MAX_US = sbh_pkg::ECHO_MAX_US_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [sbh_pkg::ADC_W-1:0]        in_adc_word,
  input  logic [sbh_pkg::ECHO_W-1:0]       in_echo_width_us,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [PWM_BITS-1:0]              out_pwm_duty,
  input  logic [sbh_pkg::TARGET_W-1:0]     out_target_cm,
  input  logic [sbh_pkg::DIST_W-1:0]       out_distance_q8,
  input  logic signed [sbh_pkg::ERR_W-1:0] out_error_q8,
  input  logic                             out_output_clipped,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [sbh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sbh_pkg::GAIN_W-1:0]       cfg_wdata,
  output int                               mismatches,
  output int                               awaited
);
  import sbh_pkg::*;

  localparam int          Q8_ONE       = 256;
  localparam int          Q16_SHIFT    = 16;
  localparam longint      INTEG_MAX    = (longint'(1) <<< (INTEG_W - 1)) - 1;
  localparam longint      INTEG_MIN    = -INTEG_MAX - 1;
  localparam logic [63:0] I_TERM_LIMIT = 64'd1 << 62;

  typedef struct packed {
    logic [PWM_BITS-1:0] pwm_duty;
    logic [TARGET_W-1:0] target_cm;
    logic [DIST_W-1:0]   distance_q8;
    logic [ERR_W-1:0]    error_q8;
    logic                output_clipped;
  } tick_result_t;

  sbh_cfg_t     regs;
  longint       integral_sum;
  longint       last_error;
  tick_result_t tick_results_q[$];

  // one control tick: updates integral and last error, returns the expected result
  function automatic tick_result_t pid_tick(input logic [ADC_W-1:0]  adc_word,
                                            input logic [ECHO_W-1:0] echo_us);
    tick_result_t r;
    logic [ADC_W-1:0] pot;
    longint target, dist_q8, err, step, delta, p_term, d_term, total, whole;
    logic [63:0] i_mag, pwm_max;
    pot = {adc_word[7:0], adc_word[15:8]} >> 4;
    if (pot > ADC_LIMIT) pot = '0;
    target = longint'(pot) * TARGET_SPAN / ADC_FULL + TARGET_BASE;
    dist_q8 = longint'(echo_us);
    if (dist_q8 > ECHO_MAX_US) dist_q8 = ECHO_MAX_US;
    dist_q8 = dist_q8 * Q8_ONE / CM_DIVISOR;
    if (dist_q8 > DIST_MAX) dist_q8 = DIST_MAX;
    err = dist_q8 - target * Q8_ONE;
    step = (regs.interval_ms == '0) ? longint'(1) : longint'(regs.interval_ms);

    integral_sum = integral_sum + err * step;
    if (integral_sum > INTEG_MAX) integral_sum = INTEG_MAX;
    if (integral_sum < INTEG_MIN) integral_sum = INTEG_MIN;
    delta = err - last_error;
    last_error = err;

    p_term = longint'(regs.gain_p) * err;
    d_term = longint'(regs.gain_d) * delta / step;
    i_mag = (integral_sum < 0) ? -integral_sum : integral_sum;
    pwm_max = (64'd1 << PWM_BITS) - 64'd1;

    r.target_cm = TARGET_W'(target);
    r.distance_q8 = DIST_W'(dist_q8);
    r.error_q8 = ERR_W'(err);
    if (regs.gain_i != '0 && i_mag > I_TERM_LIMIT / regs.gain_i) begin
      // integral term too big to add: its sign alone decides
      r.output_clipped = 1'b1;
      if (integral_sum > 0) r.pwm_duty = PWM_BITS'(pwm_max);
      else r.pwm_duty = '0;
    end else begin
      total = p_term + d_term + longint'(regs.gain_i) * integral_sum;
      whole = (total >= 0) ? (total >>> Q16_SHIFT) : -((-total) >>> Q16_SHIFT);
      if (whole < 0) begin
        r.pwm_duty = '0;
        r.output_clipped = 1'b1;
      end else if (whole > longint'(pwm_max)) begin
        r.pwm_duty = PWM_BITS'(pwm_max);
        r.output_clipped = 1'b1;
      end else begin
        r.pwm_duty = PWM_BITS'(whole);
        r.output_clipped = 1'b0;
      end
    end
    return r;
  endfunction

  task automatic check_field(input string field, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    tick_result_t want;
    if (!rst_n) begin
      regs.gain_p = GAIN_P_RST;
      regs.gain_i = GAIN_I_RST;
      regs.gain_d = GAIN_D_RST;
      regs.interval_ms = INTERVAL_RST;
      integral_sum = 0;
      last_error = 0;
      tick_results_q.delete();
      mismatches = 0;
    end else begin
      // results first, so a request taken in the same cycle is never matched to it
      if (out_valid && !out_stall) begin
        if (tick_results_q.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          want = tick_results_q.pop_front();
          check_field("pwm_duty", want.pwm_duty, out_pwm_duty);
          check_field("target_cm", want.target_cm, out_target_cm);
          check_field("distance_q8", want.distance_q8, out_distance_q8);
          check_field("error_q8", $signed(want.error_q8), out_error_q8);
          check_field("output_clipped", want.output_clipped, out_output_clipped);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (sbh_cfg_idx_t'(cfg_index))
          CFG_GAIN_P:   regs.gain_p = cfg_wdata;
          CFG_GAIN_I:   regs.gain_i = cfg_wdata;
          CFG_GAIN_D:   regs.gain_d = cfg_wdata;
          CFG_INTERVAL: regs.interval_ms = cfg_wdata[IVL_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        tick_results_q.push_back(pid_tick(in_adc_word, in_echo_width_us));
    end
    awaited = tick_results_q.size();
  end

endmodule

@@ verif/sonar_ball_height_pid_tb.sv @@
`timescale 1ns / 1ps
// sonar_ball_height_pid_tb: drives requests and config writes into the pid block, stalls
// the result side at random and reports the verdict; depends on sbh_pkg, sbh_pid_checker
// and the sonar_ball_height_pid rtl
module sonar_ball_height_pid_tb;
  import sbh_pkg::*;

  localparam int PWM_BITS    = PWM_BITS_DEF;
  localparam int ECHO_MAX_US = ECHO_MAX_US_DEF;
  localparam int CLK_PERIOD  = 8;
  localparam int RESET_CYCLES = 9;
  localparam int SETTLE_CYCLES = 64;
  // longest quiet stretch of a correct run is one request's latency plus a stall run
  // on either side; this limit is many times that
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASES = 3;
  localparam int CHUNKS = 4;
  localparam int CHUNK_REQUESTS = 72;
  // full-scale stretch at the end, long enough to pin the duty at the top
  localparam int WINDUP_REQUESTS = 120;
  // percent of well-formed requests (echo near the pot target)
  localparam int TRACKING_PCT = 85;
  localparam int ECHO_JITTER = 400;

  // config settings used per chunk
  localparam int SLOT_ZERO       = 0;
  localparam int SLOT_RESET_FAST = 1;
  localparam int SLOT_P_ONLY     = 2;
  localparam int SLOT_FULL       = 3;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [ADC_W-1:0]        in_adc_word = '0;
  logic [ECHO_W-1:0]       in_echo_width_us = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [PWM_BITS-1:0]     out_pwm_duty;
  logic [TARGET_W-1:0]     out_target_cm;
  logic [DIST_W-1:0]       out_distance_q8;
  logic signed [ERR_W-1:0] out_error_q8;
  logic                    out_output_clipped;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  sbh_cfg_idx_t            cfg_index = CFG_GAIN_P;
  logic [GAIN_W-1:0]       cfg_wdata = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;
  int mismatches;
  int awaited;

  always #(CLK_PERIOD / 2) clk = ~clk;

  sonar_ball_height_pid #(
    .PWM_BITS   (PWM_BITS),
    .ECHO_MAX_US(ECHO_MAX_US)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_adc_word       (in_adc_word),
    .in_echo_width_us  (in_echo_width_us),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pwm_duty      (out_pwm_duty),
    .out_target_cm     (out_target_cm),
    .out_distance_q8   (out_distance_q8),
    .out_error_q8      (out_error_q8),
    .out_output_clipped(out_output_clipped),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  // prediction and comparison live in the checker; it hands back the error count and
  // how many results are still owed
  sbh_pid_checker #(
    .PWM_BITS   (PWM_BITS),
    .ECHO_MAX_US(ECHO_MAX_US)
  ) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_adc_word       (in_adc_word),
    .in_echo_width_us  (in_echo_width_us),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pwm_duty      (out_pwm_duty),
    .out_target_cm     (out_target_cm),
    .out_distance_q8   (out_distance_q8),
    .out_error_q8      (out_error_q8),
    .out_output_clipped(out_output_clipped),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .mismatches        (mismatches),
    .awaited           (awaited)
  );

  // result side back-pressure, redrawn every cycle whether or not a result is up
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // watchdog: any handshake on any channel counts as progress
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("sonar_ball_height_pid_tb: done, errors");
      $finish;
    end
  end

  // one request; valid stays up from the previous request unless a gap is drawn.
  // in_stall is looked at on the falling edge, where it already holds the value
  // the next rising edge will see
  task automatic send_req(input logic [ADC_W-1:0] adc, input logic [ECHO_W-1:0] echo);
    logic taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_adc_word <= adc;
    in_echo_width_us <= echo;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  // mostly a ball hovering near the pot setpoint, sometimes raw noise on both fields
  task automatic send_tracking_req();
    logic [ADC_W-1:0]  raw;
    logic [ECHO_W-1:0] echo;
    int pot;
    int jitter;
    int near_us;
    if ($urandom_range(99) < TRACKING_PCT) begin
      pot = $urandom_range(0, ADC_LIMIT);
      raw = {pot[11:0], 4'($urandom)};
      jitter = $urandom_range(0, 2 * ECHO_JITTER);
      near_us = (TARGET_BASE + pot * TARGET_SPAN / ADC_FULL) * CM_DIVISOR + jitter - ECHO_JITTER;
      echo = (near_us < 0) ? '0 : ECHO_W'(near_us);
    end else begin
      raw = ADC_W'($urandom);
      echo = ECHO_W'($urandom);
    end
    // the block reads the conversion word with its bytes swapped
    send_req({raw[7:0], raw[15:8]}, echo);
  endtask

  task automatic put_reg(input sbh_cfg_idx_t idx, input logic [GAIN_W-1:0] value);
    logic taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  // all four registers back to back, valid held across them
  task automatic write_settings(input sbh_cfg_t s);
    logic [GAIN_W-1:0] ivl_word;
    ivl_word = GAIN_W'($urandom);
    ivl_word[IVL_W-1:0] = s.interval_ms;
    put_reg(CFG_GAIN_P, s.gain_p);
    put_reg(CFG_GAIN_I, s.gain_i);
    put_reg(CFG_GAIN_D, s.gain_d);
    // bits above the interval field are junk and must be dropped
    put_reg(CFG_INTERVAL, ivl_word);
    cfg_valid <= 1'b0;
  endtask

  // wait until every result owed has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (awaited != 0);
    @(posedge clk);
  endtask

  // gains spread over every scale, zero included
  function automatic logic [GAIN_W-1:0] rand_gain();
    return GAIN_W'($urandom_range(0, (1 << $urandom_range(0, GAIN_W)) - 1));
  endfunction

  function automatic sbh_cfg_t pick_settings(input int slot);
    sbh_cfg_t s;
    s.gain_p = rand_gain();
    s.gain_i = rand_gain();
    s.gain_d = rand_gain();
    // short intervals mostly, so the integral stays small enough to show in the duty
    if ($urandom_range(3) == 0) s.interval_ms = IVL_W'($urandom_range(0, (1 << IVL_W) - 1));
    else s.interval_ms = IVL_W'($urandom_range(0, 15));
    case (slot)
      SLOT_ZERO: s = '0;
      SLOT_RESET_FAST: begin
        s.gain_p = GAIN_P_RST;
        s.gain_i = GAIN_I_RST;
        s.gain_d = GAIN_D_RST;
        s.interval_ms = IVL_W'(1);
      end
      SLOT_P_ONLY: begin
        // unity proportional gain: duty is the error in whole cm, mostly in range
        s.gain_p = GAIN_W'(256);
        s.gain_i = '0;
        s.gain_d = '0;
        s.interval_ms = IVL_W'(1);
      end
      SLOT_FULL: s = '1;
      default: ;
    endcase
    return s;
  endfunction

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed requests at the reset gains
    send_req(16'h0000, 16'd0);      // pot at zero, no echo: sum goes negative
    send_req(16'hFFFF, 16'hFFFF);   // pot word past the limit reads as zero, echo capped
    send_req(16'h0080, 16'd18500);  // pot exactly at the limit still counts, echo at cap
    send_req(16'h1080, 16'd18501);  // one count past the limit drops to zero
    send_req(16'hF07F, 16'd18499);  // full scale pot, echo just under the cap
    send_req(16'hFF00, 16'd58);     // only the low pot bits set, one cm
    send_req(16'h00FF, 16'd1);
    send_req(16'h0F00, 16'd57);
    send_req(16'hF03F, 16'd2842);   // ball exactly on the 49 cm target
    send_req(16'hF03F, 16'd2842);   // repeat: no derivative kick
    send_req(16'hF03F, 16'd2900);
    send_req(16'hF03F, 16'd2784);
    send_req(16'h5AA5, 16'hA55A);
    send_req(16'hA55A, 16'h5AA5);

    // random part: sender-idle / receiver-stall mixes, new gains every chunk
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 17;
          recv_stall_pct = 48;
        end
        1: begin
          send_idle_pct = 48;
          recv_stall_pct = 17;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int chunk = 0; chunk < CHUNKS; chunk++) begin
        wait_drained();
        write_settings(pick_settings(phase * CHUNKS + chunk));
        repeat (CHUNK_REQUESTS) send_tracking_req();
      end
    end

    // integral windup: everything at full scale and the ball far above target, so the
    // duty sits at the top clamp while the integral keeps growing
    wait_drained();
    write_settings(pick_settings(SLOT_FULL));
    repeat (WINDUP_REQUESTS) begin
      send_req(ADC_W'($urandom), ECHO_W'($urandom_range(16'hFFFF, ECHO_MAX_US)));
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0)
      $display("sonar_ball_height_pid_tb: done, clean");
    else
      $display("sonar_ball_height_pid_tb: done, errors");
    $finish;
  end

endmodule
